/* design/dlr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types, constants and helpers for the dirty-row display refresh block.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int WIDTH       = 96;
  localparam int HEIGHT      = 64;
  localparam int PIXEL_BYTES = 2;

  localparam int PIXELS      = WIDTH * HEIGHT;
  localparam int ADDR_W      = $clog2(PIXELS);
  localparam int ROW_W       = 6;
  localparam int COL_W       = 8;
  localparam int TOTAL_BYTES = WIDTH * PIXEL_BYTES;
  localparam int BYTE_W      = $clog2(TOTAL_BYTES);
  localparam int CMD_BYTES   = 6;
  localparam int PIX_W       = 16;

  localparam logic [6:0] NO_FOLLOW = 7'd127;

  // configuration register indexes and reset values
  localparam logic [7:0] CFG_COLUMN_COMMAND = 8'd0;
  localparam logic [7:0] CFG_ROW_COMMAND    = 8'd1;
  localparam logic [7:0] COLUMN_COMMAND_RST = 8'd21;
  localparam logic [7:0] ROW_COMMAND_RST    = 8'd117;

  // positions in the address window command sequence
  localparam logic [BYTE_W-1:0] CB_COL_CMD   = BYTE_W'(0);
  localparam logic [BYTE_W-1:0] CB_COL_START = BYTE_W'(1);
  localparam logic [BYTE_W-1:0] CB_COL_END   = BYTE_W'(2);
  localparam logic [BYTE_W-1:0] CB_ROW_CMD   = BYTE_W'(3);
  localparam logic [BYTE_W-1:0] CB_ROW_START = BYTE_W'(4);
  localparam logic [BYTE_W-1:0] CB_ROW_END   = BYTE_W'(CMD_BYTES - 1);

  typedef enum logic [1:0] {
    OP_REFRESH = 2'd0,
    OP_RUN     = 2'd1,
    OP_FILL    = 2'd2,
    OP_MARK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  column;
    logic [5:0]  row;
    logic [6:0]  run_length;
    logic [15:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic [5:0] line_sent;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic sweep_step;
    logic sweep_zero;
    logic run_init;
    logic run_step;
    logic mark_all;
    logic search_init;
    logic search_step;
    logic emit_cmd;
    logic read_px;
    logic emit_data;
  } dp_cmd_t;

  typedef struct packed {
    op_t    op;
    logic   row_ok;
    phase_t phase;
    logic   sweep_last;
    logic   run_done;
    logic   found;
    logic   follow_hit;
    logic   search_last;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] pixel_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(WIDTH) + ADDR_W'(c);
  endfunction

  function automatic logic [ROW_W-1:0] row_next(logic [ROW_W-1:0] r);
    return (r == ROW_W'(HEIGHT - 1)) ? '0 : r + 1'b1;
  endfunction

endpackage

/* design/dlr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlr_ram
// Single-port RAM with synchronous write and registered read.
// ----------------------------------------------------------------------------
module dlr_ram #(
  parameter int  DATA_W = 16,
  parameter int  DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/dlr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlr_ctrl
// Sequencer: clear pass, command decode, fill and run sweeps, row search and
// byte emission steps.
// ----------------------------------------------------------------------------
module dlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dlr_pkg::dp_status_t status,
  output dlr_pkg::dp_cmd_t    cmd
);
  import dlr_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_RUN,
    ST_SEARCH,
    ST_CMD,
    ST_READ,
    ST_DATA
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.op)
          OP_RUN: begin
            if (status.row_ok) begin
              cmd.run_init = 1'b1;
              state_next   = ST_RUN;
            end else begin
              state_next = ST_IDLE;
            end
          end
          OP_FILL: begin
            cmd.mark_all = 1'b1;
            state_next   = ST_FILL;
          end
          OP_MARK: begin
            cmd.mark_all = 1'b1;
            state_next   = ST_IDLE;
          end
          default: begin
            case (status.phase)
              PH_CMD:  state_next = ST_CMD;
              PH_DATA: state_next = ST_READ;
              default: begin
                cmd.search_init = 1'b1;
                state_next      = ST_SEARCH;
              end
            endcase
          end
        endcase
      end
      ST_FILL: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_RUN: begin
        if (status.run_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.run_step = 1'b1;
        end
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.found) begin
          state_next = status.follow_hit ? ST_READ : ST_CMD;
        end else if (status.search_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_CMD: begin
        cmd.emit_cmd = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_READ: begin
        cmd.read_px = 1'b1;
        state_next  = ST_DATA;
      end
      ST_DATA: begin
        cmd.emit_data = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

  // only one source drives the RAM address at a time
  a_ram_owner: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sweep_step, cmd.run_step, cmd.read_px}))
    else $error("dlr_ctrl: more than one RAM access in a cycle");

  // an idle controller issues no work to the datapath
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(cmd.sweep_step || cmd.run_step || cmd.emit_cmd || cmd.emit_data
               || cmd.search_step))
    else $error("dlr_ctrl: datapath work issued while not busy");

  // a transfer of a new item starts with its decode
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_DECODE))
    else $error("dlr_ctrl: accepted item not decoded");

endmodule

/* design/dlr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlr_datapath
// Frame memory, dirty flags, scan pointer, transfer state and result register.
// ----------------------------------------------------------------------------
module dlr_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dlr_pkg::in_item_t   item,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  dlr_pkg::dp_cmd_t    cmd,
  output dlr_pkg::dp_status_t status,
  output logic                result_valid,
  output dlr_pkg::out_item_t  result
);
  import dlr_pkg::*;

  in_item_t          item_q;
  logic [7:0]        column_command;
  logic [7:0]        row_command;
  logic [HEIGHT-1:0] dirty;
  logic [ROW_W-1:0]  scan_pointer;
  logic [ROW_W-1:0]  current_line;
  logic [6:0]        follow_line;
  phase_t            phase;
  logic [BYTE_W-1:0] byte_count;
  logic [ADDR_W-1:0] sweep_addr;
  logic [COL_W-1:0]  run_col;
  logic [6:0]        run_left;
  logic [ROW_W-1:0]  search_row;
  logic [ROW_W-1:0]  search_count;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [PIX_W-1:0]  ram_rdata;
  logic [7:0]        cmd_byte;
  logic [7:0]        data_byte;
  logic              fin;

  assign status.op          = op_t'(item_q.opcode);
  assign status.row_ok      = ({1'b0, item_q.row} < 7'(HEIGHT));
  assign status.phase       = phase;
  assign status.sweep_last  = (sweep_addr == ADDR_W'(PIXELS - 1));
  assign status.run_done    = (run_col >= COL_W'(WIDTH)) || (run_left == '0);
  assign status.found       = dirty[search_row];
  assign status.follow_hit  = (follow_line == {1'b0, search_row});
  assign status.search_last = (search_count == ROW_W'(HEIGHT - 1));

  assign ram_we    = cmd.sweep_step || cmd.run_step;
  assign ram_wdata = cmd.sweep_zero ? '0 : item_q.pixel_color;

  always_comb begin
    if (cmd.sweep_step) begin
      ram_addr = sweep_addr;
    end else if (cmd.run_step) begin
      ram_addr = pixel_addr(item_q.row, run_col);
    end else begin
      ram_addr = pixel_addr(current_line, COL_W'(byte_count >> 1));
    end
  end

  dlr_ram #(
    .DATA_W(PIX_W),
    .DEPTH (PIXELS)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (byte_count)
      CB_COL_CMD:   cmd_byte = column_command;
      CB_COL_START: cmd_byte = '0;
      CB_COL_END:   cmd_byte = 8'(WIDTH - 1);
      CB_ROW_CMD:   cmd_byte = row_command;
      CB_ROW_START: cmd_byte = 8'(current_line);
      default:      cmd_byte = 8'(HEIGHT - 1);
    endcase
  end

  // low byte first
  assign data_byte = byte_count[0] ? ram_rdata[15:8] : ram_rdata[7:0];
  assign fin       = (byte_count == BYTE_W'(TOTAL_BYTES - 1));

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_command <= COLUMN_COMMAND_RST;
      row_command    <= ROW_COMMAND_RST;
      dirty          <= '1;
      scan_pointer   <= '0;
      current_line   <= '0;
      follow_line    <= NO_FOLLOW;
      phase          <= PH_IDLE;
      byte_count     <= '0;
      sweep_addr     <= '0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= cmd.emit_cmd || cmd.emit_data;
      if (cfg_write) begin
        if (cfg_index == CFG_COLUMN_COMMAND) column_command <= cfg_data;
        if (cfg_index == CFG_ROW_COMMAND)    row_command    <= cfg_data;
      end
      if (cmd.sweep_step) begin
        sweep_addr <= status.sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (cmd.mark_all) begin
        dirty <= '1;
      end else if (cmd.run_init) begin
        dirty[item_q.row] <= 1'b1;
      end else if (cmd.search_step && status.found) begin
        dirty[search_row] <= 1'b0;
      end
      if (cmd.search_step && status.found) begin
        scan_pointer <= row_next(search_row);
        current_line <= search_row;
        byte_count   <= '0;
        phase        <= status.follow_hit ? PH_DATA : PH_CMD;
      end
      if (cmd.emit_cmd) begin
        if (byte_count == CB_ROW_END) begin
          phase      <= PH_DATA;
          byte_count <= '0;
        end else begin
          byte_count <= byte_count + 1'b1;
        end
      end
      if (cmd.emit_data) begin
        if (fin) begin
          phase       <= PH_IDLE;
          byte_count  <= '0;
          follow_line <= {1'b0, current_line} + 7'd1;
        end else begin
          byte_count <= byte_count + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= item;
    end
    if (cmd.run_init) begin
      run_col  <= COL_W'(item_q.column);
      run_left <= item_q.run_length;
    end else if (cmd.run_step) begin
      run_col  <= run_col + 1'b1;
      run_left <= run_left - 1'b1;
    end
    if (cmd.search_init) begin
      search_row   <= scan_pointer;
      search_count <= '0;
    end else if (cmd.search_step) begin
      search_row   <= row_next(search_row);
      search_count <= search_count + 1'b1;
    end
    if (cmd.emit_cmd) begin
      result <= '{spi_byte: cmd_byte, is_data: 1'b0, line_sent: current_line, last: 1'b0};
    end else if (cmd.emit_data) begin
      result <= '{spi_byte: data_byte, is_data: 1'b1, line_sent: current_line, last: fin};
    end
  end

  // at most one byte per refresh tick, never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("dlr_datapath: back-to-back result strobes");

  // command bytes never close a row
  a_cmd_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.is_data) |-> !result.last)
    else $error("dlr_datapath: last set on a command byte");

  // the command sequence stays inside its six bytes
  a_cmd_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CMD) |-> (byte_count < BYTE_W'(CMD_BYTES)))
    else $error("dlr_datapath: command byte count out of range");

endmodule

/* design/dirty_line_display_refresh.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_line_display_refresh
// Frame buffer with per-row dirty flags and a byte-serial display refresh.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers when start is high and busy is low.
//   Opcodes: refresh tick, run write, fill all, mark all dirty.
//   Results: at most one per refresh tick, shown for one cycle with
//   result_valid high; the receiver cannot stall the block.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high. Write registers only while busy is low.
// Sequencing, from the accepting edge to the result strobe:
//   a command byte passes decode and emit; a pixel byte passes decode, a
//   registered frame RAM read and emit. A tick with an idle transfer
//   first scans one row per cycle from the scan pointer, through at most
//   every row. busy drops in the cycle the result is shown.
//   Run write: decode, then a write of each pixel. Fill: one frame RAM
//   word per cycle. Mark all dirty: decode only.
// Reset: all rows are marked dirty and a clearing pass zeroes the frame
//   RAM; busy stays high until it completes.
// ----------------------------------------------------------------------------
module dirty_line_display_refresh (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dlr_pkg::in_item_t  item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               result_valid,
  output dlr_pkg::out_item_t result
);
  import dlr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dlr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  dlr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
